[rtl/dfms_pkg.sv]
// ----------------------------------------------------------------------------
// dfms_pkg - shared definitions for the deduplicating message store
// Widths, operation and status codes, and the control bundle that the
// sequencer hands to the entry store.
// ----------------------------------------------------------------------------
package dfms_pkg;

  localparam int STORE_DEPTH_DEF = 64;
  localparam int ID_W            = 256;
  localparam int WORD_W          = 64;
  localparam int HANDLE_W        = 32;
  localparam int TALLY_W         = 7;
  localparam int OPCODE_W        = 2;
  localparam int STATUS_W        = 3;

  typedef logic [ID_W-1:0]     id_t;
  typedef logic [HANDLE_W-1:0] handle_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ADD   = 2'd0,
    OP_MARK  = 2'd1,
    OP_LIST  = 2'd2,
    OP_COUNT = 2'd3
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED      = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_MARKED     = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_LIST_ENTRY = 3'd4,
    ST_LIST_EMPTY = 3'd5,
    ST_COUNT      = 3'd6
  } status_t;

  // Control bundle from the sequencer to the entry store.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic mark_en;
    logic mark_val;
  } store_ctl_t;

endpackage

[rtl/dedup_fifo_message_store_top.sv]
// ----------------------------------------------------------------------------
// dedup_fifo_message_store_top - deduplicating FIFO message store
// A bounded ring of entries keyed by a 256-bit message id, with payload
// handles and read marks, supporting add, mark read, list and count.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Words carried
//  --------  ----------------------  ------------------------------------------
//  command   start, accepted !busy   opcode, id_word0..3, payload_handle,
//                                    read_flag, skip_read, list_limit
//  result    done, one cycle each    status, out_id_word0..3, out_handle,
//                                    out_read, tally, last
//
// A count is answered in the cycle after the command word is taken and leaves
// busy low. Add and mark read walk the stored entries oldest first through
// one shared id comparator, one slot a cycle: a miss keeps busy high until
// every entry has passed the comparator, and a hit ends the walk as soon as
// the comparator reports it. A list walks the entries newest first at the
// same pace, giving up to one result word a cycle; it covers the whole store
// unless the limit is met first, and it stops in the cycle after the entry
// that meets the limit is selected. The final result word is on the ports
// in the same cycle that busy falls. Each slot read passes the memory read
// stage and the registered comparator before its verdict is known.
// Reset clears the ring pointers and occupancy at once; the entry memories
// are never cleared, since only slots holding live entries are ever read.
// The receiver cannot stall: each result word is on the ports for exactly
// one cycle, marked by done, and last flags the final word of a command.
//
// The sequencer keeps the oldest slot and the next free slot (tail) of the
// ring. When the store is full the tail equals the oldest slot, so an add
// overwrites the evicted entry in place and moves both pointers on. The
// duplicate search covers every entry before the eviction takes place.
//
module dedup_fifo_message_store_top #(
  parameter int STORE_DEPTH = dfms_pkg::STORE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [dfms_pkg::OPCODE_W-1:0]     opcode,
  input  logic [dfms_pkg::WORD_W-1:0]       id_word0,
  input  logic [dfms_pkg::WORD_W-1:0]       id_word1,
  input  logic [dfms_pkg::WORD_W-1:0]       id_word2,
  input  logic [dfms_pkg::WORD_W-1:0]       id_word3,
  input  logic [dfms_pkg::HANDLE_W-1:0]     payload_handle,
  input  logic                              read_flag,
  input  logic                              skip_read,
  input  logic [dfms_pkg::TALLY_W-1:0]      list_limit,
  output logic                              done,
  output logic [dfms_pkg::STATUS_W-1:0]     status,
  output logic [dfms_pkg::WORD_W-1:0]       out_id_word0,
  output logic [dfms_pkg::WORD_W-1:0]       out_id_word1,
  output logic [dfms_pkg::WORD_W-1:0]       out_id_word2,
  output logic [dfms_pkg::WORD_W-1:0]       out_id_word3,
  output logic [dfms_pkg::HANDLE_W-1:0]     out_handle,
  output logic                              out_read,
  output logic [dfms_pkg::TALLY_W-1:0]      tally,
  output logic                              last
);

  localparam int SLOT_W = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);

  dfms_pkg::store_ctl_t ctl;
  logic [SLOT_W-1:0]    rd_slot;
  logic [SLOT_W-1:0]    wr_slot;
  dfms_pkg::handle_t    wr_handle;
  dfms_pkg::id_t        rd_id;
  dfms_pkg::handle_t    rd_handle;
  logic                 rd_mark;
  dfms_pkg::id_t        key;
  dfms_pkg::id_t        key_in;
  dfms_pkg::id_t        out_id;
  logic                 cmp_valid;
  logic [SLOT_W-1:0]    cmp_slot;
  logic                 hit_valid;
  logic                 hit;
  logic [SLOT_W-1:0]    hit_slot;

  // The id is kept as one 256-bit word with word 0 in the low bits.
  assign key_in = {id_word3, id_word2, id_word1, id_word0};
  assign out_id_word0 = out_id[dfms_pkg::WORD_W-1:0];
  assign out_id_word1 = out_id[2*dfms_pkg::WORD_W-1:dfms_pkg::WORD_W];
  assign out_id_word2 = out_id[3*dfms_pkg::WORD_W-1:2*dfms_pkg::WORD_W];
  assign out_id_word3 = out_id[4*dfms_pkg::WORD_W-1:3*dfms_pkg::WORD_W];

  dfms_ctrl #(
    .STORE_DEPTH (STORE_DEPTH),
    .SLOT_W      (SLOT_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .opcode         (opcode),
    .key_in         (key_in),
    .handle_in      (payload_handle),
    .read_flag_in   (read_flag),
    .skip_read_in   (skip_read),
    .limit_in       (list_limit),
    .busy           (busy),
    .ctl            (ctl),
    .rd_slot        (rd_slot),
    .wr_slot        (wr_slot),
    .wr_handle      (wr_handle),
    .rd_id          (rd_id),
    .rd_handle      (rd_handle),
    .rd_mark        (rd_mark),
    .key            (key),
    .cmp_valid      (cmp_valid),
    .cmp_slot       (cmp_slot),
    .hit_valid      (hit_valid),
    .hit            (hit),
    .hit_slot       (hit_slot),
    .done           (done),
    .status         (status),
    .out_id         (out_id),
    .out_handle     (out_handle),
    .out_read       (out_read),
    .tally          (tally),
    .last           (last)
  );

  dfms_store #(
    .STORE_DEPTH (STORE_DEPTH),
    .SLOT_W      (SLOT_W)
  ) u_store (
    .clk       (clk),
    .ctl       (ctl),
    .rd_slot   (rd_slot),
    .wr_slot   (wr_slot),
    .wr_id     (key),
    .wr_handle (wr_handle),
    .rd_id     (rd_id),
    .rd_handle (rd_handle),
    .rd_mark   (rd_mark)
  );

  dfms_match #(
    .SLOT_W (SLOT_W)
  ) u_match (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmp_valid),
    .in_slot   (cmp_slot),
    .stored_id (rd_id),
    .key       (key),
    .hit_valid (hit_valid),
    .hit       (hit),
    .hit_slot  (hit_slot)
  );

`ifndef NO_ASSERTIONS
  // Every accepted command either occupies the sequencer or is answered.
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither busy nor answered");

  // A count is answered in the very next cycle as a single word.
  a_count_single: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode == dfms_pkg::OP_COUNT)) |=> (done && last))
    else $error("count not answered at once");

  // The store is walked only while a command is in progress.
  a_read_while_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.rd_en |-> busy)
    else $error("store read while idle");

  // An id write always carries the read mark of the new entry.
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |-> ctl.mark_en)
    else $error("entry write without its read mark");
`endif

endmodule

[rtl/dfms_store.sv]
// ----------------------------------------------------------------------------
// dfms_store - entry memories
// Message ids, payload handles and read marks, one slot per entry, with
// registered read data.
// ----------------------------------------------------------------------------
module dfms_store #(
  parameter int STORE_DEPTH = dfms_pkg::STORE_DEPTH_DEF,
  parameter int SLOT_W      = $clog2(STORE_DEPTH)
) (
  input  logic                 clk,
  input  dfms_pkg::store_ctl_t ctl,
  input  logic [SLOT_W-1:0]    rd_slot,
  input  logic [SLOT_W-1:0]    wr_slot,
  input  dfms_pkg::id_t        wr_id,
  input  dfms_pkg::handle_t    wr_handle,
  output dfms_pkg::id_t        rd_id,
  output dfms_pkg::handle_t    rd_handle,
  output logic                 rd_mark
);

  dfms_pkg::id_t     id_mem     [STORE_DEPTH];
  dfms_pkg::handle_t handle_mem [STORE_DEPTH];
  logic              mark_mem   [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      id_mem[wr_slot]     <= wr_id;
      handle_mem[wr_slot] <= wr_handle;
    end
    if (ctl.mark_en) begin
      mark_mem[wr_slot] <= ctl.mark_val;
    end
    if (ctl.rd_en) begin
      rd_id     <= id_mem[rd_slot];
      rd_handle <= handle_mem[rd_slot];
      rd_mark   <= mark_mem[rd_slot];
    end
  end

endmodule

[rtl/dfms_match.sv]
// ----------------------------------------------------------------------------
// dfms_match - shared id comparator
// Compares one stored id against the search key each cycle and registers
// the verdict together with the slot it belongs to.
// ----------------------------------------------------------------------------
module dfms_match #(
  parameter int SLOT_W = 6
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [SLOT_W-1:0] in_slot,
  input  dfms_pkg::id_t     stored_id,
  input  dfms_pkg::id_t     key,
  output logic              hit_valid,
  output logic              hit,
  output logic [SLOT_W-1:0] hit_slot
);

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_valid <= 1'b0;
    end else begin
      hit_valid <= in_valid;
    end
    hit      <= (stored_id == key);
    hit_slot <= in_slot;
  end

endmodule

[rtl/dfms_ctrl.sv]
// ----------------------------------------------------------------------------
// dfms_ctrl - command sequencer
// Holds the ring pointers and occupancy, walks the store one slot a cycle
// for searches and listings, and forms the result words.
// ----------------------------------------------------------------------------
module dfms_ctrl #(
  parameter int STORE_DEPTH = dfms_pkg::STORE_DEPTH_DEF,
  parameter int SLOT_W      = $clog2(STORE_DEPTH),
  parameter int CNT_W       = $clog2(STORE_DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [dfms_pkg::OPCODE_W-1:0]     opcode,
  input  dfms_pkg::id_t                     key_in,
  input  dfms_pkg::handle_t                 handle_in,
  input  logic                              read_flag_in,
  input  logic                              skip_read_in,
  input  logic [dfms_pkg::TALLY_W-1:0]      limit_in,
  output logic                              busy,
  // store side
  output dfms_pkg::store_ctl_t              ctl,
  output logic [SLOT_W-1:0]                 rd_slot,
  output logic [SLOT_W-1:0]                 wr_slot,
  output dfms_pkg::handle_t                 wr_handle,
  input  dfms_pkg::id_t                     rd_id,
  input  dfms_pkg::handle_t                 rd_handle,
  input  logic                              rd_mark,
  // comparator side
  output dfms_pkg::id_t                     key,
  output logic                              cmp_valid,
  output logic [SLOT_W-1:0]                 cmp_slot,
  input  logic                              hit_valid,
  input  logic                              hit,
  input  logic [SLOT_W-1:0]                 hit_slot,
  // results
  output logic                              done,
  output logic [dfms_pkg::STATUS_W-1:0]     status,
  output dfms_pkg::id_t                     out_id,
  output dfms_pkg::handle_t                 out_handle,
  output logic                              out_read,
  output logic [dfms_pkg::TALLY_W-1:0]      tally,
  output logic                              last
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(STORE_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(STORE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SRCH = 3'b010,
    S_LIST = 3'b100
  } state_t;

  state_t                         state;
  state_t                         state_next;
  logic [dfms_pkg::OPCODE_W-1:0]  op;
  logic                           flag;
  logic                           skip_read;
  logic [dfms_pkg::TALLY_W-1:0]   limit;
  logic [SLOT_W-1:0]              oldest;
  logic [SLOT_W-1:0]              tail;
  logic [CNT_W-1:0]               occ;
  logic [SLOT_W-1:0]              walk_slot;
  logic [CNT_W-1:0]               walk_left;
  logic [dfms_pkg::TALLY_W-1:0]   cnt;
  logic                           pend_valid;
  dfms_pkg::id_t                  pend_id;
  dfms_pkg::handle_t              pend_handle;
  logic                           pend_mark;
  logic [dfms_pkg::TALLY_W-1:0]   pend_tally;

  logic                           issue;
  logic                           found;
  logic                           miss;
  logic                           full;
  logic                           finish;
  logic                           sel;
  logic                           is_add;
  logic [SLOT_W-1:0]              tail_inc;
  logic [SLOT_W-1:0]              tail_dec;
  logic [SLOT_W-1:0]              oldest_inc;
  logic [SLOT_W-1:0]              walk_inc;
  logic [SLOT_W-1:0]              walk_dec;

  logic                           emit;
  logic [dfms_pkg::STATUS_W-1:0]  status_next;
  dfms_pkg::id_t                  out_id_next;
  dfms_pkg::handle_t              out_handle_next;
  logic                           out_read_next;
  logic [dfms_pkg::TALLY_W-1:0]   tally_next;
  logic                           last_next;

  assign busy       = (state != S_IDLE);
  assign is_add     = (op == dfms_pkg::OP_ADD);
  assign full       = (occ == FULL_CNT);
  assign tail_inc   = (tail == LAST_SLOT) ? '0 : tail + 1'b1;
  assign tail_dec   = (tail == '0) ? LAST_SLOT : tail - 1'b1;
  assign oldest_inc = (oldest == LAST_SLOT) ? '0 : oldest + 1'b1;
  assign walk_inc   = (walk_slot == LAST_SLOT) ? '0 : walk_slot + 1'b1;
  assign walk_dec   = (walk_slot == '0) ? LAST_SLOT : walk_slot - 1'b1;

  // A hit ends a search at once; a miss waits until the walk and both
  // pipeline stages are empty.
  assign found  = (state == S_SRCH) && hit_valid && hit;
  assign miss   = (state == S_SRCH) && !hit_valid && !cmp_valid && (walk_left == '0);
  assign finish = (state == S_LIST) &&
                  ((cnt >= limit) || ((walk_left == '0) && !cmp_valid));
  assign sel    = (state == S_LIST) && !finish && cmp_valid && !(skip_read && rd_mark);
  assign issue  = (walk_left != '0) &&
                  (((state == S_SRCH) && !found) || ((state == S_LIST) && !finish));

  assign rd_slot      = walk_slot;
  assign wr_slot      = is_add ? tail : hit_slot;

  always_comb begin
    ctl.rd_en    = issue;
    ctl.wr_en    = miss && is_add;
    ctl.mark_en  = (miss && is_add) || (found && (op == dfms_pkg::OP_MARK));
    ctl.mark_val = is_add ? flag : 1'b1;
  end

  always_comb begin
    state_next      = state;
    emit            = 1'b0;
    status_next     = dfms_pkg::ST_COUNT;
    out_id_next     = '0;
    out_handle_next = '0;
    out_read_next   = 1'b0;
    tally_next      = '0;
    last_next       = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (opcode)
            dfms_pkg::OP_ADD, dfms_pkg::OP_MARK: state_next = S_SRCH;
            dfms_pkg::OP_LIST:                   state_next = S_LIST;
            default: begin
              emit       = 1'b1;
              tally_next = dfms_pkg::TALLY_W'(occ);
            end
          endcase
        end
      end
      S_SRCH: begin
        if (found) begin
          emit        = 1'b1;
          status_next = is_add ? dfms_pkg::ST_DUPLICATE : dfms_pkg::ST_MARKED;
          state_next  = S_IDLE;
        end else if (miss) begin
          emit        = 1'b1;
          status_next = is_add ? dfms_pkg::ST_ADDED : dfms_pkg::ST_NOT_FOUND;
          state_next  = S_IDLE;
        end
      end
      S_LIST: begin
        // The selected entry is held back in the pend registers so that the final
        // one can carry the last flag.
        if (finish) begin
          emit       = 1'b1;
          state_next = S_IDLE;
          if (pend_valid) begin
            status_next     = dfms_pkg::ST_LIST_ENTRY;
            out_id_next     = pend_id;
            out_handle_next = pend_handle;
            out_read_next   = pend_mark;
            tally_next      = pend_tally;
          end else begin
            status_next = dfms_pkg::ST_LIST_EMPTY;
          end
        end else if (sel && pend_valid) begin
          emit            = 1'b1;
          status_next     = dfms_pkg::ST_LIST_ENTRY;
          out_id_next     = pend_id;
          out_handle_next = pend_handle;
          out_read_next   = pend_mark;
          tally_next      = pend_tally;
          last_next       = 1'b0;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      oldest     <= '0;
      tail       <= '0;
      occ        <= '0;
      walk_left  <= '0;
      cnt        <= '0;
      cmp_valid  <= 1'b0;
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= issue;
      done      <= emit;
      if (issue) begin
        walk_left <= walk_left - CNT_W'(1);
        walk_slot <= (state == S_LIST) ? walk_dec : walk_inc;
      end
      if ((state == S_IDLE) && start) begin
        key         <= key_in;
        wr_handle   <= handle_in;
        op          <= opcode;
        flag        <= read_flag_in;
        skip_read   <= skip_read_in;
        limit       <= limit_in;
        walk_left   <= occ;
        walk_slot   <= (opcode == dfms_pkg::OP_LIST) ? tail_dec : oldest;
        cnt         <= '0;
        pend_valid  <= 1'b0;
      end
      if (ctl.wr_en) begin
        tail <= tail_inc;
        if (full) begin
          oldest <= oldest_inc;
        end else begin
          occ <= occ + CNT_W'(1);
        end
      end
      if (sel) begin
        pend_valid  <= 1'b1;
        pend_id     <= rd_id;
        pend_handle <= rd_handle;
        pend_mark   <= rd_mark;
        pend_tally  <= cnt + 1'b1;
        cnt         <= cnt + 1'b1;
      end
    end
    cmp_slot <= walk_slot;
    if (emit) begin
      status     <= status_next;
      out_id     <= out_id_next;
      out_handle <= out_handle_next;
      out_read   <= out_read_next;
      tally      <= tally_next;
      last       <= last_next;
    end
  end

endmodule

[tb/sv/dedup_fifo_message_store_top_tb.sv]
// ----------------------------------------------------------------------------
// dedup_fifo_message_store_top_tb - self-checking bench for the message store
// Drives command words through the start/busy handshake, first from a short
// table of directed rows and then from a random mix that fills the store,
// forces evictions and repeats ids. Every result word is checked field by
// field against a typed-in expectation or the behavioural copy kept in the bench.
// ----------------------------------------------------------------------------
module dedup_fifo_message_store_top_tb;

  localparam int DEPTH          = dfms_pkg::STORE_DEPTH_DEF;
  localparam int TW             = dfms_pkg::TALLY_W;
  localparam int RANDOM_CMDS    = 188;
  localparam int CALM_TAIL      = 40;    // final random commands sent with no idling
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving on either side
  localparam int DRAIN_CYCLES   = 150;   // settle time after the last expected result
  localparam int SHOWN_FAULTS   = 10;

  // One command word, with an optional typed-in expectation for rows whose
  // answer is obvious (a single result word with all data fields but the tally zero).
  typedef struct {
    dfms_pkg::opcode_t    op;
    dfms_pkg::id_t        id;
    dfms_pkg::handle_t    handle;
    logic                 rflag;
    logic                 unread;
    logic [TW-1:0]        limit;
    bit                   typed;
    dfms_pkg::status_t    t_status;
    logic [TW-1:0]        t_tally;
  } cmd_t;

  // One result word as the store should present it.
  typedef struct {
    dfms_pkg::status_t    status;
    dfms_pkg::id_t        id;
    dfms_pkg::handle_t    handle;
    logic                 rd;
    logic [TW-1:0]        tally;
    logic                 last;
  } reply_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [dfms_pkg::OPCODE_W-1:0] opcode = '0;
  logic [dfms_pkg::WORD_W-1:0]   id_word0 = '0;
  logic [dfms_pkg::WORD_W-1:0]   id_word1 = '0;
  logic [dfms_pkg::WORD_W-1:0]   id_word2 = '0;
  logic [dfms_pkg::WORD_W-1:0]   id_word3 = '0;
  logic [dfms_pkg::HANDLE_W-1:0] payload_handle = '0;
  logic                          read_flag = 1'b0;
  logic                          skip_read = 1'b0;
  logic [TW-1:0]                 list_limit = '0;
  logic                          done;
  logic [dfms_pkg::STATUS_W-1:0] status;
  logic [dfms_pkg::WORD_W-1:0]   out_id_word0;
  logic [dfms_pkg::WORD_W-1:0]   out_id_word1;
  logic [dfms_pkg::WORD_W-1:0]   out_id_word2;
  logic [dfms_pkg::WORD_W-1:0]   out_id_word3;
  logic [dfms_pkg::HANDLE_W-1:0] out_handle;
  logic                          out_read;
  logic [TW-1:0]                 tally;
  logic                          last;

  dedup_fifo_message_store_top #(
    .STORE_DEPTH(DEPTH)
  ) u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .opcode         (opcode),
    .id_word0       (id_word0),
    .id_word1       (id_word1),
    .id_word2       (id_word2),
    .id_word3       (id_word3),
    .payload_handle (payload_handle),
    .read_flag      (read_flag),
    .skip_read      (skip_read),
    .list_limit     (list_limit),
    .done           (done),
    .status         (status),
    .out_id_word0   (out_id_word0),
    .out_id_word1   (out_id_word1),
    .out_id_word2   (out_id_word2),
    .out_id_word3   (out_id_word3),
    .out_handle     (out_handle),
    .out_read       (out_read),
    .tally          (tally),
    .last           (last)
  );

  // Clock with a period of 20 time units.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Behavioural copy of the store. It is a ring of DEPTH slots: ring_oldest
  // points at the oldest live entry and ring_fill counts the live entries.
  // Only live slots are ever read, so the memories need no initial value.
  // --------------------------------------------------------------------------
  dfms_pkg::id_t     ring_id     [DEPTH];
  dfms_pkg::handle_t ring_handle [DEPTH];
  logic              ring_read   [DEPTH];
  int unsigned       ring_oldest = 0;
  int unsigned       ring_fill   = 0;

  reply_t            fresh_replies[$];   // result words for the command just taken
  reply_t            awaited_replies[$]; // result words still to come, oldest first
  dfms_pkg::id_t     issued_ids[$];      // every id ever offered to an add

  int          fault_count   = 0;
  int          cmds_taken    = 0;
  int          words_checked = 0;
  int          evictions     = 0;
  int          list_words    = 0;

  function automatic int unsigned ring_slot(int unsigned age);
    return (ring_oldest + age) % DEPTH;
  endfunction

  // Searches the live entries oldest first; returns the slot or -1.
  function automatic int ring_find(dfms_pkg::id_t key);
    for (int unsigned i = 0; i < ring_fill; i++) begin
      if (ring_id[ring_slot(i)] == key) return int'(ring_slot(i));
    end
    return -1;
  endfunction

  function automatic reply_t plain_reply(dfms_pkg::status_t st, logic [TW-1:0] tl);
    reply_t r;
    r.status = st;
    r.id     = '0;
    r.handle = '0;
    r.rd     = 1'b0;
    r.tally  = tl;
    r.last   = 1'b1;
    return r;
  endfunction

  // Applies one command to the copy of the store and leaves the result words
  // it should produce in fresh_replies.
  function automatic void predict_store_reply(cmd_t c);
    int                 hit;
    int unsigned        slot;
    int unsigned        cap;
    int unsigned        emitted;
    reply_t             r;
    fresh_replies.delete();
    hit = ring_find(c.id);
    unique case (c.op)
      dfms_pkg::OP_ADD: begin
        if (hit >= 0) begin
          fresh_replies.push_back(plain_reply(dfms_pkg::ST_DUPLICATE, '0));
        end else begin
          // A full store drops its oldest entry before the new one goes in.
          if (ring_fill >= DEPTH) begin
            ring_oldest = (ring_oldest + 1) % DEPTH;
            ring_fill   = DEPTH - 1;
            evictions++;
          end
          slot = ring_slot(ring_fill);
          ring_id[slot]     = c.id;
          ring_handle[slot] = c.handle;
          ring_read[slot]   = c.rflag;
          ring_fill++;
          fresh_replies.push_back(plain_reply(dfms_pkg::ST_ADDED, '0));
        end
      end
      dfms_pkg::OP_MARK: begin
        if (hit >= 0) begin
          ring_read[hit] = 1'b1;
          fresh_replies.push_back(plain_reply(dfms_pkg::ST_MARKED, '0));
        end else begin
          fresh_replies.push_back(plain_reply(dfms_pkg::ST_NOT_FOUND, '0));
        end
      end
      dfms_pkg::OP_LIST: begin
        cap     = (c.limit > DEPTH) ? DEPTH : c.limit;
        emitted = 0;
        for (int unsigned i = ring_fill; i > 0 && emitted < cap; i--) begin
          slot = ring_slot(i - 1);
          if (!(c.unread && ring_read[slot])) begin
            emitted++;
            r.status = dfms_pkg::ST_LIST_ENTRY;
            r.id     = ring_id[slot];
            r.handle = ring_handle[slot];
            r.rd     = ring_read[slot];
            r.tally  = TW'(emitted);
            r.last   = 1'b0;
            fresh_replies.push_back(r);
          end
        end
        if (emitted == 0) fresh_replies.push_back(plain_reply(dfms_pkg::ST_LIST_EMPTY, '0));
        else fresh_replies[fresh_replies.size() - 1].last = 1'b1;
      end
      default: begin
        fresh_replies.push_back(plain_reply(dfms_pkg::ST_COUNT, TW'(ring_fill)));
      end
    endcase
  endfunction

  // Presents one command word and waits until the store takes it. The store
  // takes a word at a rising edge where start is high and busy is low.
  task automatic issue_command(cmd_t c);
    opcode         <= c.op;
    id_word0       <= c.id[63:0];
    id_word1       <= c.id[127:64];
    id_word2       <= c.id[191:128];
    id_word3       <= c.id[255:192];
    payload_handle <= c.handle;
    read_flag      <= c.rflag;
    skip_read      <= c.unread;
    list_limit     <= c.limit;
    start          <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    // The word was taken at this edge; the bench copy moves on with it.
    predict_store_reply(c);
    if (c.typed) awaited_replies.push_back(plain_reply(c.t_status, c.t_tally));
    else foreach (fresh_replies[k]) awaited_replies.push_back(fresh_replies[k]);
    if (c.op == dfms_pkg::OP_ADD) issued_ids.push_back(c.id);
    cmds_taken++;
  endtask

  // Lets the sender idle for a random burst, with start low.
  task automatic sender_pause();
    start <= 1'b0;
    repeat ($urandom_range(1, 12)) @(posedge clk);
  endtask

  function automatic dfms_pkg::id_t random_id();
    return {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
  endfunction

  // An id offered recently, so it may still be live or may have been evicted.
  function automatic dfms_pkg::id_t recent_id();
    int lo;
    lo = (issued_ids.size() > 90) ? issued_ids.size() - 90 : 0;
    return issued_ids[$urandom_range(lo, issued_ids.size() - 1)];
  endfunction

  // A recent id with one bit flipped, which seldom matches a live entry.
  function automatic dfms_pkg::id_t near_miss_id();
    return recent_id() ^ (dfms_pkg::id_t'(1) << $urandom_range(0, dfms_pkg::ID_W - 1));
  endfunction

  function automatic cmd_t row(dfms_pkg::opcode_t op, dfms_pkg::id_t id,
                               dfms_pkg::handle_t h, logic rf, logic uo,
                               logic [TW-1:0] lim, bit typed, dfms_pkg::status_t st,
                               logic [TW-1:0] tl);
    cmd_t c;
    c.op       = op;
    c.id       = id;
    c.handle   = h;
    c.rflag    = rf;
    c.unread   = uo;
    c.limit    = lim;
    c.typed    = typed;
    c.t_status = st;
    c.t_tally  = tl;
    return c;
  endfunction

  // Builds a random command. Most of them are well formed, so that the store
  // fills, evicts and is searched for ids it really holds; the rest carry
  // fresh or near-miss ids. Fields that an operation ignores are random too.
  function automatic cmd_t random_command();
    cmd_t        c;
    int unsigned pick;
    c = row(dfms_pkg::OP_COUNT, random_id(), $urandom, 1'(($urandom)), 1'(($urandom)),
            TW'($urandom_range(0, 127)), 1'b0, dfms_pkg::ST_ADDED, '0);
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      c.op = dfms_pkg::OP_ADD;
      pick = $urandom_range(0, 99);
      if (pick >= 90) c.id = near_miss_id();
      else if (pick >= 70) c.id = recent_id();
    end else if (pick < 70) begin
      c.op = dfms_pkg::OP_MARK;
      pick = $urandom_range(0, 99);
      if (pick < 70) c.id = recent_id();
      else if (pick < 85) c.id = near_miss_id();
    end else if (pick < 86) begin
      c.op = dfms_pkg::OP_LIST;
      pick = $urandom_range(0, 99);
      // Short lists mostly; now and then the whole store, a zero or an out-of-range limit.
      if (pick < 65) c.limit = TW'($urandom_range(1, 6));
      else if (pick < 75) c.limit = TW'(DEPTH);
      else if (pick < 82) c.limit = '0;
      else if (pick < 90) c.limit = TW'($urandom_range(DEPTH + 1, 127));
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker. The receiver cannot hold results off, so every cycle in
  // which done is high carries one result word that is taken at the edge
  // closing that cycle. It is compared with the oldest word still awaited.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    reply_t want;
    if (!rst && done === 1'b1) begin
      if (awaited_replies.size() == 0) begin
        fault_count++;
        if (fault_count <= SHOWN_FAULTS)
          $display("[%0t] unexpected result word: status %0d tally %0d last %0b",
                   $realtime, status, tally, last);
      end else begin
        want = awaited_replies.pop_front();
        words_checked++;
        if (status !== want.status || out_id_word0 !== want.id[63:0] ||
            out_id_word1 !== want.id[127:64] || out_id_word2 !== want.id[191:128] ||
            out_id_word3 !== want.id[255:192] || out_handle !== want.handle ||
            out_read !== want.rd || tally !== want.tally || last !== want.last) begin
          fault_count++;
          if (fault_count <= SHOWN_FAULTS) begin
            $display("[%0t] result word %0d differs", $realtime, words_checked);
            $display("  expected: status %0d id %h handle %h read %0b tally %0d last %0b",
                     want.status, want.id, want.handle, want.rd, want.tally, want.last);
            $display("  actual:   status %0d id %h handle %h read %0b tally %0d last %0b",
                     status, {out_id_word3, out_id_word2, out_id_word1, out_id_word0},
                     out_handle, out_read, tally, last);
          end
        end
        if (want.status == dfms_pkg::ST_LIST_ENTRY) list_words++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: counts cycles in which no word moves on either side. Even the
  // longest id search plus the longest sender pause is well under the limit.
  // --------------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || done === 1'b1 || (start && busy === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles, %0d result words outstanding",
               WATCHDOG_LIMIT, awaited_replies.size());
      $display("FAIL dedup_fifo_message_store_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  localparam dfms_pkg::id_t ID_ZERO = '0;
  localparam dfms_pkg::id_t ID_ONES = '1;
  // only the top bit of word 3
  localparam dfms_pkg::id_t ID_TOP  = dfms_pkg::id_t'(1) << (dfms_pkg::ID_W - 1);
  // only the bottom bit of word 0
  localparam dfms_pkg::id_t ID_LOW  = dfms_pkg::id_t'(1);
  // only the bottom bit of word 1
  localparam dfms_pkg::id_t ID_W1   = dfms_pkg::id_t'(1) << dfms_pkg::WORD_W;

  localparam dfms_pkg::opcode_t C_ADD   = dfms_pkg::OP_ADD;
  localparam dfms_pkg::opcode_t C_MARK  = dfms_pkg::OP_MARK;
  localparam dfms_pkg::opcode_t C_LIST  = dfms_pkg::OP_LIST;
  localparam dfms_pkg::opcode_t C_COUNT = dfms_pkg::OP_COUNT;

  cmd_t directed_cmds[$];

  initial begin
    // Directed rows. The typed expectations are the obvious ones: an empty
    // store after reset, plain acknowledgements, duplicates and misses.
    // Listings that return entries are left to the bench copy of the store.
    directed_cmds.push_back(row(C_COUNT, ID_ZERO, '0, 1'b0, 1'b0, '0, 1,
                                dfms_pkg::ST_COUNT, '0));
    directed_cmds.push_back(row(C_LIST, ID_ZERO, '0, 1'b0, 1'b0, 7'd64, 1,
                                dfms_pkg::ST_LIST_EMPTY, '0));
    directed_cmds.push_back(row(C_MARK, ID_ZERO, '0, 1'b0, 1'b0, '0, 1,
                                dfms_pkg::ST_NOT_FOUND, '0));
    directed_cmds.push_back(row(C_ADD, ID_ZERO, '0, 1'b0, 1'b0, '0, 1,
                                dfms_pkg::ST_ADDED, '0));
    directed_cmds.push_back(row(C_ADD, ID_ONES, '1, 1'b1, 1'b1, '1, 1,
                                dfms_pkg::ST_ADDED, '0));
    directed_cmds.push_back(row(C_ADD, ID_ZERO, 32'h5a5a_a5a5, 1'b1, 1'b0, '0, 1,
                                dfms_pkg::ST_DUPLICATE, '0));
    directed_cmds.push_back(row(C_ADD, ID_TOP, 32'h8000_0000, 1'b0, 1'b0, '0, 1,
                                dfms_pkg::ST_ADDED, '0));
    directed_cmds.push_back(row(C_ADD, ID_LOW, 32'h0000_0001, 1'b0, 1'b0, '0, 1,
                                dfms_pkg::ST_ADDED, '0));
    directed_cmds.push_back(row(C_MARK, ID_W1, '0, 1'b0, 1'b0, '0, 1,
                                dfms_pkg::ST_NOT_FOUND, '0));
    // A zero limit lists nothing even though the store holds entries.
    directed_cmds.push_back(row(C_LIST, ID_ZERO, '0, 1'b0, 1'b0, '0, 1,
                                dfms_pkg::ST_LIST_EMPTY, '0));
    // A limit above the store depth is clipped to the depth.
    directed_cmds.push_back(row(C_LIST, ID_ZERO, '0, 1'b0, 1'b0, 7'd127, 0,
                                dfms_pkg::ST_ADDED, '0));
    directed_cmds.push_back(row(C_LIST, ID_ZERO, '0, 1'b0, 1'b0, 7'd1, 0,
                                dfms_pkg::ST_ADDED, '0));
    directed_cmds.push_back(row(C_LIST, ID_ZERO, '0, 1'b0, 1'b1, 7'd64, 0,
                                dfms_pkg::ST_ADDED, '0));
    directed_cmds.push_back(row(C_MARK, ID_ZERO, '0, 1'b0, 1'b0, '0, 1,
                                dfms_pkg::ST_MARKED, '0));
    // Marking an entry that is already read still reports it as marked.
    directed_cmds.push_back(row(C_MARK, ID_ONES, '1, 1'b1, 1'b1, '1, 1,
                                dfms_pkg::ST_MARKED, '0));
    directed_cmds.push_back(row(C_LIST, ID_ZERO, '0, 1'b0, 1'b1, 7'd2, 0,
                                dfms_pkg::ST_ADDED, '0));
    directed_cmds.push_back(row(C_COUNT, ID_ONES, '1, 1'b1, 1'b1, '1, 1,
                                dfms_pkg::ST_COUNT, 7'd4));
    directed_cmds.push_back(row(C_ADD, ID_TOP, 32'h1234_5678, 1'b1, 1'b0, '0, 1,
                                dfms_pkg::ST_DUPLICATE, '0));
    directed_cmds.push_back(row(C_MARK, ID_LOW, '0, 1'b0, 1'b0, '0, 1,
                                dfms_pkg::ST_MARKED, '0));
    directed_cmds.push_back(row(C_MARK, ID_TOP, '0, 1'b0, 1'b0, '0, 1,
                                dfms_pkg::ST_MARKED, '0));
    // Nothing is selected once every entry is read.
    directed_cmds.push_back(row(C_LIST, ID_ZERO, '0, 1'b0, 1'b1, 7'd64, 1,
                                dfms_pkg::ST_LIST_EMPTY, '0));
    directed_cmds.push_back(row(C_LIST, ID_ZERO, '0, 1'b0, 1'b0, 7'd64, 0,
                                dfms_pkg::ST_ADDED, '0));

    // Reset is held once, at the start of the run.
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_cmds[i]) begin
      issue_command(directed_cmds[i]);
      if ($urandom_range(0, 3) == 0) sender_pause();
    end

    // Random part: pauses come in bursts, with quiet stretches between, and
    // the final stretch runs back to back.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      issue_command(random_command());
      if (n < RANDOM_CMDS - CALM_TAIL && $urandom_range(0, 9) < 3) sender_pause();
    end
    start <= 1'b0;

    while (awaited_replies.size() != 0) @(posedge clk);
    // Any stray result word after this point is caught by the checker.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d commands and %0d result words, %0d of them list entries;",
             cmds_taken, words_checked, list_words);
    $display("the store of depth %0d evicted %0d entries, %0d faults seen.",
             DEPTH, evictions, fault_count);
    if (fault_count == 0 && awaited_replies.size() == 0) begin
      $display("PASS dedup_fifo_message_store_top");
    end else begin
      $display("FAIL dedup_fifo_message_store_top");
    end
    $finish;
  end

endmodule
